// File: design/lramt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_pkg: shared types and constants
// Tree geometry, node word layout, command and result structs.
// ----------------------------------------------------------------------------
package lramt_pkg;

   localparam int LEAVES     = 1024;
   localparam int LEVELS     = $clog2(LEAVES);
   localparam int SPAN       = 1 << LEVELS;
   localparam int NODES      = 2 * SPAN - 1;
   localparam int NODE_W     = $clog2(NODES);
   localparam int LVL_W      = $clog2(LEVELS + 1);
   localparam int LRET_W     = $clog2(LEVELS);
   localparam int IDX_W      = 10;
   localparam int VAL_W      = 31;

   localparam logic [VAL_W-1:0] TOP_VALUE = {VAL_W{1'b1}};

   typedef enum logic [1:0] {
      MODE_ASSIGN = 2'd0,
      MODE_READ   = 2'd1,
      MODE_MIN    = 2'd2,
      MODE_SPARE  = 2'd3   // unused: no effect, no result
   } mode_type;

   typedef struct packed {
      logic [VAL_W-1:0] min_val;
      logic [VAL_W-1:0] tag_val;
      logic             tag_valid;
   } node_word_type;

   typedef struct packed {
      logic                wr_en;
      logic [NODE_W-1:0]   wr_addr;
      node_word_type       wr_data;
      logic [NODE_W-1:0]   rd_addr;
   } mem_req_type;

   typedef struct packed {
      logic [1:0]       mode;
      logic [IDX_W-1:0] range_lo;
      logic [IDX_W-1:0] range_hi;
      logic [IDX_W-1:0] point_index;
      logic [VAL_W-1:0] new_value;
   } cmd_type;

   typedef struct packed {
      logic             valid;
      logic [VAL_W-1:0] answer;
   } res_type;

endpackage

// File: design/lramt_node_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_node_ram: node store
// One write and one registered read per cycle, one word per tree node.
// ----------------------------------------------------------------------------
module lramt_node_ram
   import lramt_pkg::*;
(
   input  logic          clock,
   input  mem_req_type   mem_req,
   output node_word_type rd_data
);

   node_word_type mem [NODES];

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      rd_data <= mem[mem_req.rd_addr];
   end

endmodule

// File: design/lramt_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_seq: tree walk sequencer
// Depth-first walk with one shared range compare and min unit.
// ----------------------------------------------------------------------------
module lramt_seq
   import lramt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  cmd_type       cmd,
   output logic          idle,
   output res_type       res,
   input  logic          res_ack,
   output mem_req_type   mem_req,
   input  node_word_type rd_data
);

   typedef enum logic [8:0] {
      ST_CLEAR   = 9'b000000001,
      ST_IDLE    = 9'b000000010,
      ST_READ    = 9'b000000100,
      ST_EVAL    = 9'b000001000,
      ST_PUSHL   = 9'b000010000,
      ST_PUSHR   = 9'b000100000,
      ST_RET     = 9'b001000000,
      ST_COMBINE = 9'b010000000,
      ST_OUT     = 9'b100000000
   } state_type;

   state_type        state_ff, state_in;
   logic [LVL_W-1:0] level_ff, level_in;
   logic [IDX_W-1:0] pos_ff, pos_in;
   logic [VAL_W-1:0] acc_ff, acc_in;
   logic [VAL_W-1:0] ret_ff, ret_in;
   logic [VAL_W-1:0] tag_ff, tag_in;
   logic [IDX_W-1:0] a_ff, a_in, b_ff, b_in;
   logic [VAL_W-1:0] v_ff, v_in;
   logic             assign_ff, assign_in;
   logic [NODE_W-1:0] clr_ff, clr_in;
   logic [VAL_W-1:0] lret_ff [LEVELS];
   logic             lret_we;
   logic [LRET_W-1:0] lret_wa;

   logic [NODE_W-1:0] node_idx, left_idx, right_idx;
   logic [LVL_W-1:0]  shift;
   logic [IDX_W-1:0]  seg_lo, seg_hi;
   logic              full_cov, disjoint, is_leaf, child_leaf;
   logic [VAL_W-1:0]  comb_min;

   // node geometry from level and position
   always_comb begin
      node_idx  = ({{(NODE_W-1){1'b0}}, 1'b1} << level_ff) - {{(NODE_W-1){1'b0}}, 1'b1}
                  + NODE_W'(pos_ff);
      left_idx  = {node_idx[NODE_W-2:0], 1'b1};
      right_idx = left_idx + {{(NODE_W-1){1'b0}}, 1'b1};
      shift     = LVL_W'(LEVELS) - level_ff;
      seg_lo    = pos_ff << shift;
      seg_hi    = seg_lo | ~({IDX_W{1'b1}} << shift);
      full_cov  = (a_ff <= seg_lo) && (seg_hi <= b_ff);
      disjoint  = (seg_hi < a_ff) || (seg_lo > b_ff);
      is_leaf   = (level_ff == LVL_W'(LEVELS));
      child_leaf = (level_ff == LVL_W'(LEVELS - 1));
      comb_min  = (lret_ff[level_ff[LRET_W-1:0]] < ret_ff) ?
                  lret_ff[level_ff[LRET_W-1:0]] : ret_ff;
   end

   always_comb begin
      state_in  = state_ff;
      level_in  = level_ff;
      pos_in    = pos_ff;
      acc_in    = acc_ff;
      ret_in    = ret_ff;
      tag_in    = tag_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      v_in      = v_ff;
      assign_in = assign_ff;
      clr_in    = clr_ff;
      lret_we   = 1'b0;
      lret_wa   = level_ff[LRET_W-1:0] - LRET_W'(1);
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = node_idx;
      mem_req.wr_data = '{min_val: TOP_VALUE, tag_val: '0, tag_valid: 1'b0};
      mem_req.rd_addr = node_idx;
      res.valid  = 1'b0;
      res.answer = acc_ff;

      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = clr_ff;
            clr_in = clr_ff + {{(NODE_W-1){1'b0}}, 1'b1};
            if (clr_ff == NODE_W'(NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               level_in  = '0;
               pos_in    = '0;
               acc_in    = TOP_VALUE;
               a_in      = cmd.range_lo;
               b_in      = cmd.range_hi;
               v_in      = cmd.new_value;
               assign_in = 1'b0;
               case (cmd.mode)
                  MODE_ASSIGN: begin
                     assign_in = 1'b1;
                     if (cmd.range_lo <= cmd.range_hi) state_in = ST_READ;
                  end
                  MODE_READ: begin
                     a_in     = cmd.point_index;
                     b_in     = cmd.point_index;
                     state_in = ST_READ;
                  end
                  MODE_MIN: begin
                     state_in = (cmd.range_lo <= cmd.range_hi) ? ST_READ : ST_OUT;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (disjoint) begin
               ret_in   = rd_data.min_val;
               state_in = ST_RET;
            end else if (full_cov) begin
               if (assign_ff) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_data = '{min_val: v_ff, tag_val: v_ff, tag_valid: !is_leaf};
                  ret_in = v_ff;
               end else begin
                  if (rd_data.min_val < acc_ff) acc_in = rd_data.min_val;
                  ret_in = rd_data.min_val;
               end
               state_in = ST_RET;
            end else if (rd_data.tag_valid && !assign_ff) begin
               // whole subtree holds the pending value
               if (rd_data.tag_val < acc_ff) acc_in = rd_data.tag_val;
               state_in = ST_RET;
            end else if (rd_data.tag_valid) begin
               tag_in   = rd_data.tag_val;
               state_in = ST_PUSHL;
            end else begin
               level_in = level_ff + LVL_W'(1);
               pos_in   = pos_ff << 1;
               state_in = ST_READ;
            end
         end
         ST_PUSHL: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = left_idx;
            mem_req.wr_data = '{min_val: tag_ff, tag_val: tag_ff, tag_valid: !child_leaf};
            state_in = ST_PUSHR;
         end
         ST_PUSHR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = right_idx;
            mem_req.wr_data = '{min_val: tag_ff, tag_val: tag_ff, tag_valid: !child_leaf};
            level_in = level_ff + LVL_W'(1);
            pos_in   = pos_ff << 1;
            state_in = ST_READ;
         end
         ST_RET: begin
            if (level_ff == '0) begin
               state_in = assign_ff ? ST_IDLE : ST_OUT;
            end else if (!pos_ff[0]) begin
               lret_we  = 1'b1;
               pos_in   = pos_ff | IDX_W'(1);
               state_in = ST_READ;
            end else begin
               level_in = level_ff - LVL_W'(1);
               pos_in   = pos_ff >> 1;
               state_in = ST_COMBINE;
            end
         end
         ST_COMBINE: begin
            ret_in = comb_min;
            if (assign_ff) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_data = '{min_val: comb_min, tag_val: '0, tag_valid: 1'b0};
            end
            state_in = ST_RET;
         end
         ST_OUT: begin
            res.valid = 1'b1;
            if (res_ack) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign idle = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      level_ff  <= level_in;
      pos_ff    <= pos_in;
      acc_ff    <= acc_in;
      ret_ff    <= ret_in;
      tag_ff    <= tag_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      v_ff      <= v_in;
      assign_ff <= assign_in;
      if (lret_we) lret_ff[lret_wa] <= ret_ff;
   end

endmodule

// File: design/lazy_range_assign_min_tree.sv
`timescale 1ns / 1ps
// Walk: each tree node visited passes through read, evaluate and return; a merge
//   adds a combine step, and a pending push writes the left and then the right
//   child; an empty minimum goes straight to the result.
// Throughput: one word at a time; req_tready stays low for the whole walk.
// Reset: synchronous; a clearing pass over all 2047 nodes (one node per cycle)
//   follows, with req_tready low until it completes.
// ----------------------------------------------------------------------------
// lazy_range_assign_min_tree: lazy segment tree, range assign / range min
// Input decode, sequencer, node store and result register.
// ----------------------------------------------------------------------------
module lazy_range_assign_min_tree
   import lramt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // range_lo, range_hi, point_index, new_value, pad
   input  logic [1:0]  req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // answer, pad
);

   cmd_type       cmd;
   res_type       res;
   mem_req_type   mem_req;
   node_word_type rd_data;
   logic          seq_idle, start, res_ack;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0] rsp_data_ff, rsp_data_in;

   // unpack the input word
   always_comb begin
      cmd.mode        = req_tuser;
      cmd.range_lo    = req_tdata[9:0];
      cmd.range_hi    = req_tdata[19:10];
      cmd.point_index = req_tdata[29:20];
      cmd.new_value   = req_tdata[60:30];
   end

   assign req_tready = seq_idle;
   assign start      = req_tvalid && seq_idle;

   // output register frees the sequencer while a result waits
   assign res_ack = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (res.valid && res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res.answer;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   lramt_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .cmd     (cmd),
      .idle    (seq_idle),
      .res     (res),
      .res_ack (res_ack),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   lramt_node_ram u_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule

// File: design/lramt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_checker: port-level checks
// Watches the top-level ports; attached by bind.
// ----------------------------------------------------------------------------
module lramt_checker
   import lramt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp word changed while stalled");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[31])
      else $error("rsp pad bit set");

   a_busy_after_read: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser == MODE_READ |=> !req_tready)
      else $error("ready during tree walk");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !req_tready && !rsp_tvalid)
      else $error("not clearing after reset");

endmodule

bind lazy_range_assign_min_tree lramt_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// File: tb/lramt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lramt_scoreboard: request/response scoreboard for the range-assign min tree
// Watches both streams, keeps a flat image of the element array, predicts
// each read and minimum answer, and compares the response words in order.
// ----------------------------------------------------------------------------
module lramt_scoreboard
   import lramt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,
   input  logic [1:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   output int          fail_count,
   output int          pending_answers
);

   // Flat element image; lazy marks only change when values land, not what
   // they are, so a plain array is an exact model.
   logic [VAL_W-1:0] element_val [SPAN];
   logic [VAL_W-1:0] answer_queue [$];

   function automatic logic [VAL_W-1:0] range_min(int lo, int hi);
      logic [VAL_W-1:0] m;
      m = TOP_VALUE;
      for (int i = lo; i <= hi && i < SPAN; i++)
         if (element_val[i] < m) m = element_val[i];
      return m;
   endfunction

   always @(posedge clock) begin
      logic [IDX_W-1:0] lo, hi, idx;
      logic [VAL_W-1:0] val, got, want;
      lo  = req_tdata[9:0];
      hi  = req_tdata[19:10];
      idx = req_tdata[29:20];
      val = req_tdata[60:30];
      if (reset) begin
         for (int i = 0; i < SPAN; i++) element_val[i] = TOP_VALUE;
         answer_queue.delete();
         fail_count <= 0;
         pending_answers <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            case (req_tuser)
               MODE_ASSIGN: begin
                  for (int i = lo; i <= hi && i < SPAN; i++) element_val[i] = val;
               end
               MODE_READ: begin
                  answer_queue = {answer_queue, element_val[idx]};
               end
               MODE_MIN: begin
                  answer_queue = {answer_queue,
                                  (lo <= hi) ? range_min(lo, hi) : TOP_VALUE};
               end
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[VAL_W-1:0];
            if (answer_queue.size() == 0) begin
               $error("answer: unexpected word, actual %0d", got);
               fail_count <= fail_count + 1;
            end else begin
               want = answer_queue.pop_front();
               if (got !== want) begin
                  $error("answer: expected %0d actual %0d", want, got);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_answers <= answer_queue.size();
      end
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for lazy_range_assign_min_tree
// Directed corner words, then random assign/read/min words with random
// idle bursts on both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import lramt_pkg::*;

   localparam int RANDOM_WORDS = 1830;
   localparam int CYCLE_LIMIT  = 2_000_000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // range_lo, range_hi, point_index, new_value, pad
   logic [1:0]  req_tuser;   // mode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // answer, pad

   int  fail_count;
   int  pending_answers;
   int  cycle_count;
   bit  calm;        // no idling in the last part of the run
   bit  hold_done;   // long hold-off already done

   lazy_range_assign_min_tree u_top (.*);

   lramt_scoreboard u_chk (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Runaway guard.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side: random stall bursts, one long hold-off to back up the block.
   initial begin
      int n;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!hold_done && cycle_count > 6000) begin
            hold_done = 1;
            rsp_tready <= 1'b0;
            repeat (600) @(negedge clock);
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 18);
            rsp_tready <= 1'b0;
            repeat (n) @(negedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end
      end
   end

   // Drive one request word and wait for acceptance at a rising edge.
   task automatic send_word(logic [1:0] mode, int lo, int hi, int idx, int val);
      req_tuser  <= mode;
      req_tdata  <= {3'b0, val[30:0], idx[9:0], hi[9:0], lo[9:0]};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(negedge clock);
      end
   endtask

   function automatic int rand_value();
      case ($urandom_range(0, 3))
         0: return int'(TOP_VALUE);
         1: return int'($urandom_range(0, 15));
         default: return int'($urandom() & 32'h7FFF_FFFF);
      endcase
   endfunction

   initial begin
      int lo, hi, width;
      logic [1:0] mode;
      calm = 0;
      hold_done = 0;
      cycle_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = MODE_ASSIGN;
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Directed: fresh tree, full range, extremes, empty ranges, unused mode.
      send_word(MODE_MIN, 0, 1023, 0, 0);
      send_word(MODE_READ, 0, 0, 1023, 0);
      send_word(MODE_ASSIGN, 0, 1023, 0, int'(TOP_VALUE) - 1);
      send_word(MODE_MIN, 0, 1023, 0, 0);
      send_word(MODE_ASSIGN, 100, 700, 0, 5);
      send_word(MODE_ASSIGN, 300, 301, 0, 0);
      send_word(MODE_READ, 0, 0, 300, 0);
      send_word(MODE_READ, 0, 0, 699, 0);
      send_word(MODE_MIN, 0, 299, 0, 0);
      send_word(MODE_MIN, 302, 1023, 0, 0);
      send_word(MODE_ASSIGN, 1023, 1023, 0, 1);
      send_word(MODE_READ, 0, 0, 1023, 0);
      send_word(MODE_ASSIGN, 500, 400, 0, 0);
      send_word(MODE_MIN, 500, 400, 0, 0);
      send_word(MODE_SPARE, 0, 1023, 0, 0);
      send_word(MODE_ASSIGN, 0, 0, 0, int'(TOP_VALUE));
      send_word(MODE_READ, 0, 0, 0, 0);
      send_word(MODE_MIN, 0, 1, 0, 0);
      send_word(MODE_ASSIGN, 0, 1023, 0, 32'h2AAA_AAAA);
      send_word(MODE_MIN, 512, 512, 0, 0);
      send_word(MODE_ASSIGN, 0, 1023, 0, 32'h5555_5555);
      send_word(MODE_READ, 0, 0, 511, 0);

      // Random: mostly short ranges, a few wide ones, a little noise.
      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k > RANDOM_WORDS - 200) calm = 1;
         width = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023)
                                             : $urandom_range(0, 40);
         lo = $urandom_range(0, 1023);
         hi = lo + width;
         if (hi > 1023) hi = 1023;
         if ($urandom_range(0, 19) == 0) begin
            lo = $urandom_range(0, 1023);
            hi = $urandom_range(0, 1023);
         end
         case ($urandom_range(0, 19))
            0: mode = MODE_SPARE;
            1, 2, 3, 4, 5, 6: mode = MODE_ASSIGN;
            7, 8, 9, 10, 11, 12: mode = MODE_READ;
            default: mode = MODE_MIN;
         endcase
         send_word(mode, lo, hi, $urandom_range(0, 1023), rand_value());
      end
      req_tvalid <= 1'b0;

      while (pending_answers != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// File: lazy_range_assign_min_tree.f
design/lramt_pkg.sv
design/lramt_node_ram.sv
design/lramt_seq.sv
design/lazy_range_assign_min_tree.sv
design/lramt_checker.sv
tb/lramt_checker.sv
tb/tb_top.sv
